/* src/qrb_pkg.sv */
// Shared types and constants of the quadratic root bisection block.
package qrb_pkg;

    localparam int XW       = 32;              // Q-format word width
    localparam int TOL_W    = 31;              // tolerance register width
    localparam int DIGIT_W  = 16;              // multiplier digit handled per cell
    localparam int MC_W     = 64;              // multiplicand width (a, then a*x + b)
    localparam int PROD_W   = MC_W + DIGIT_W + 1;
    // Holds (a*x + b*2^F)*x + c*2^2F exactly for every FRAC_BITS up to 30.
    localparam int ACC_W    = 97;
    localparam int NCELL    = 4;

    localparam int MAX_ITER_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);
    localparam logic signed [XW-1:0] F_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [XW-1:0] F_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        R_LOW_SMALL  = 2'd0,
        R_HIGH_SMALL = 2'd1,
        R_NARROW     = 2'd2,
        R_LIMIT      = 2'd3
    } t_reason;

    // Which evaluation point a word in the multiply chain belongs to.
    typedef enum logic [1:0] {
        TAG_LO  = 2'd0,
        TAG_HI  = 2'd1,
        TAG_MID = 2'd2
    } t_tag;

    typedef struct packed {
        logic signed [XW-1:0] start_low;
        logic signed [XW-1:0] start_high;
        logic signed [XW-1:0] coef_square;
        logic signed [XW-1:0] coef_linear;
        logic signed [XW-1:0] coef_const;
    } t_job;

    typedef struct packed {
        logic signed [XW-1:0] root;
        t_reason              finish_reason;
    } t_result;

    typedef struct packed {
        logic                    vld;
        t_tag                    tag;
        logic signed [XW-1:0]    x;
        logic signed [MC_W-1:0]  mcand;
        logic signed [ACC_W-1:0] acc;
    } t_tok;

    typedef struct packed {
        logic                 vld;
        t_tag                 tag;
        logic signed [XW-1:0] f;
    } t_fval;

endpackage

/* src/qrb_cell.sv */
// One multiply-accumulate cell of the polynomial evaluation chain.
module qrb_cell #(
    parameter bit LOW_DIGIT = 1'b0,
    parameter bit RELOAD    = 1'b0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qrb_pkg::t_tok                    i_tok,
    input  logic signed [qrb_pkg::ACC_W-1:0] i_addend,
    output qrb_pkg::t_tok                    o_tok
);

    logic signed [qrb_pkg::DIGIT_W:0]      w_digit;
    logic signed [qrb_pkg::PROD_W-1:0]     w_prod;
    logic signed [qrb_pkg::ACC_W-1:0]      w_base;
    logic signed [qrb_pkg::ACC_W-1:0]      w_sum;
    qrb_pkg::t_tok                         n_tok;
    qrb_pkg::t_tok                         r_tok;

    always_comb begin
        // High digit is signed, low digit is a plain unsigned fraction of x.
        if (LOW_DIGIT) begin
            w_digit = {1'b0, i_tok.x[qrb_pkg::DIGIT_W-1:0]};
            w_base  = i_tok.acc <<< qrb_pkg::DIGIT_W;
        end else begin
            w_digit = {i_tok.x[qrb_pkg::XW-1], i_tok.x[qrb_pkg::XW-1 -: qrb_pkg::DIGIT_W]};
            w_base  = i_tok.acc;
        end
        w_prod = i_tok.mcand * w_digit;
        w_sum  = w_base
               + {{(qrb_pkg::ACC_W-qrb_pkg::PROD_W){w_prod[qrb_pkg::PROD_W-1]}}, w_prod}
               + i_addend;

        n_tok     = i_tok;
        if (RELOAD) begin
            // Hand the finished inner term on as the next multiplicand.
            n_tok.mcand = w_sum[qrb_pkg::MC_W-1:0];
            n_tok.acc   = '0;
        end else begin
            n_tok.acc   = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/qrb_sat.sv */
// Output stage of the evaluation chain: drop fraction bits and saturate.
module qrb_sat #(
    parameter int FRAC_BITS = qrb_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qrb_pkg::t_tok  i_tok,
    output qrb_pkg::t_fval o_fval
);

    localparam int SH = 2 * FRAC_BITS;

    logic signed [qrb_pkg::ACC_W-1:0]     w_sh;
    logic [qrb_pkg::ACC_W-qrb_pkg::XW:0]  w_top;
    logic                                 w_fits;
    qrb_pkg::t_fval                       n_fval;
    qrb_pkg::t_fval                       r_fval;

    always_comb begin
        w_sh   = i_tok.acc >>> SH;
        w_top  = w_sh[qrb_pkg::ACC_W-1:qrb_pkg::XW-1];
        w_fits = (&w_top) || !(|w_top);
        n_fval.vld = i_tok.vld;
        n_fval.tag = i_tok.tag;
        if (w_fits) begin
            n_fval.f = w_sh[qrb_pkg::XW-1:0];
        end else if (i_tok.acc[qrb_pkg::ACC_W-1]) begin
            n_fval.f = qrb_pkg::F_MIN;
        end else begin
            n_fval.f = qrb_pkg::F_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fval.vld <= 1'b0;
        end else begin
            r_fval <= n_fval;
        end
    end

    assign o_fval = r_fval;

endmodule

/* src/quadratic_root_bisection.sv */
// Top level of the quadratic root finder: bisection controller and evaluation chain.
//
// Usage: present a job word on i_job (interval ends and coefficients a, b, c,
// signed Q16.16) and raise start; the word is taken at a rising edge where
// start is high and busy is low. busy stays high until the result is out. The result
// word (root and finish_reason) on o_result is marked by o_done, high for exactly
// one cycle; the receiver must take it then, it cannot stall. The tolerance register
// is written by i_cfg_we / i_cfg_wdata; the user must do so while idle, unenforced.
//
// f(x) = (a*x + b*2^F)*x + c*2^2F runs through a row of four multiply cells,
// each taking one 16-bit digit of x against a 64-bit multiplicand, followed
// by a saturating stage. The first iteration sends the low end, high end and
// midpoint; later iterations reuse the kept end values and send only the new
// midpoint. Each iteration runs through issue, chain and decide in turn.
// o_done and a falling busy come in the same cycle; a new job may start then.
// Reset returns the block to idle, drops any job in flight and sets the
// tolerance to 66.
module quadratic_root_bisection #(
    parameter int MAX_ITER  = qrb_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = qrb_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  qrb_pkg::t_job               i_job,
    output logic                        o_done,
    output qrb_pkg::t_result            o_result,
    input  logic                        i_cfg_we,
    input  logic [qrb_pkg::TOL_W-1:0]   i_cfg_wdata
);

    localparam int ITER_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(MAX_ITER - 1);
    localparam int XW = qrb_pkg::XW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DECIDE
    } t_state;

    t_state                  r_state;
    qrb_pkg::t_job           r_coef;
    logic signed [XW-1:0]    r_low;
    logic signed [XW-1:0]    r_high;
    logic signed [XW-1:0]    r_mid;
    logic signed [XW-1:0]    r_f_lo;
    logic signed [XW-1:0]    r_f_hi;
    logic signed [XW-1:0]    r_f_mid;
    logic [qrb_pkg::TOL_W-1:0] r_tol;
    logic [ITER_W-1:0]       r_iter;
    qrb_pkg::t_tag           r_issue_tag;
    logic                    r_done;
    qrb_pkg::t_result        r_result;

    qrb_pkg::t_tok                     w_head;
    qrb_pkg::t_tok                     w_tok [0:qrb_pkg::NCELL];
    logic signed [qrb_pkg::ACC_W-1:0]  w_add [0:qrb_pkg::NCELL-1];
    qrb_pkg::t_fval                    w_fres;

    logic [XW:0]             w_sum33;
    logic signed [XW-1:0]    w_mid;
    logic signed [XW-1:0]    w_x;
    logic [XW:0]             w_diff;
    logic [XW:0]             w_width;
    logic [XW:0]             w_tol33;
    logic                    w_lo_small;
    logic                    w_hi_small;
    logic                    w_narrow;
    logic                    w_same;
    logic signed [XW-1:0]    w_new_low;

    function automatic logic [XW:0] abs33(input logic signed [XW-1:0] v);
        logic [XW:0] ext;
        ext = {v[XW-1], v};
        return v[XW-1] ? ((XW+1)'(0) - ext) : ext;
    endfunction

    // Midpoint rounds toward minus infinity; 33-bit sum never overflows.
    assign w_sum33 = {r_low[XW-1], r_low} + {r_high[XW-1], r_high};
    assign w_mid   = w_sum33[XW:1];

    always_comb begin
        unique case (r_issue_tag)
            qrb_pkg::TAG_LO: w_x = r_low;
            qrb_pkg::TAG_HI: w_x = r_high;
            default:         w_x = w_mid;
        endcase
    end

    // Feed the head of the chain: multiplicand a, empty accumulator.
    always_comb begin
        w_head.vld   = (r_state == S_ISSUE);
        w_head.tag   = r_issue_tag;
        w_head.x     = w_x;
        w_head.mcand = {{(qrb_pkg::MC_W-XW){r_coef.coef_square[XW-1]}},
                        r_coef.coef_square};
        w_head.acc   = '0;
    end

    assign w_tok[0] = w_head;

    // b enters after a*x is complete, c after the second product.
    always_comb begin
        for (int i = 0; i < qrb_pkg::NCELL; i++) begin
            w_add[i] = '0;
        end
        w_add[1] = {{(qrb_pkg::ACC_W-XW){r_coef.coef_linear[XW-1]}},
                    r_coef.coef_linear} <<< FRAC_BITS;
        w_add[3] = {{(qrb_pkg::ACC_W-XW){r_coef.coef_const[XW-1]}},
                    r_coef.coef_const} <<< (2 * FRAC_BITS);
    end

    for (genvar g = 0; g < qrb_pkg::NCELL; g++) begin : g_cell
        qrb_cell #(
            .LOW_DIGIT ((g % 2) == 1),
            .RELOAD    (g == 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_addend (w_add[g]),
            .o_tok    (w_tok[g+1])
        );
    end

    qrb_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[qrb_pkg::NCELL]),
        .o_fval  (w_fres)
    );

    // Stop tests in priority order, then the sign-class choice.
    always_comb begin
        w_diff     = {r_low[XW-1], r_low} - {r_high[XW-1], r_high};
        // Full 33-bit difference: take magnitude from the 33-bit value.
        if (w_diff[XW]) begin
            w_width = (XW+1)'(0) - w_diff;
        end else begin
            w_width = w_diff;
        end
        w_tol33    = {2'b00, r_tol};
        w_lo_small = abs33(r_f_lo) < w_tol33;
        w_hi_small = abs33(r_f_hi) < w_tol33;
        w_narrow   = w_width < w_tol33;
        w_same     = (r_f_mid[XW-1] == r_f_hi[XW-1]);
        w_new_low  = w_same ? r_low : r_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tol   <= qrb_pkg::TOL_RESET;
            r_low   <= '0;
            r_high  <= '0;
            r_iter  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            // Capture each evaluated point as it leaves the chain.
            if (w_fres.vld) begin
                unique case (w_fres.tag)
                    qrb_pkg::TAG_LO:  r_f_lo  <= w_fres.f;
                    qrb_pkg::TAG_HI:  r_f_hi  <= w_fres.f;
                    qrb_pkg::TAG_MID: r_f_mid <= w_fres.f;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_coef      <= i_job;
                        r_low       <= i_job.start_low;
                        r_high      <= i_job.start_high;
                        r_iter      <= '0;
                        r_issue_tag <= qrb_pkg::TAG_LO;
                        r_state     <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    unique case (r_issue_tag)
                        qrb_pkg::TAG_LO: r_issue_tag <= qrb_pkg::TAG_HI;
                        qrb_pkg::TAG_HI: r_issue_tag <= qrb_pkg::TAG_MID;
                        default: begin
                            r_mid   <= w_mid;
                            r_state <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: begin
                    // Midpoint goes in last, so its arrival closes the iteration.
                    if (w_fres.vld && (w_fres.tag == qrb_pkg::TAG_MID)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (w_lo_small) begin
                        r_done                 <= 1'b1;
                        r_result.root          <= r_low;
                        r_result.finish_reason <= qrb_pkg::R_LOW_SMALL;
                        r_state                <= S_IDLE;
                    end else if (w_hi_small) begin
                        r_done                 <= 1'b1;
                        r_result.root          <= r_high;
                        r_result.finish_reason <= qrb_pkg::R_HIGH_SMALL;
                        r_state                <= S_IDLE;
                    end else if (w_narrow) begin
                        r_done                 <= 1'b1;
                        r_result.root          <= r_low;
                        r_result.finish_reason <= qrb_pkg::R_NARROW;
                        r_state                <= S_IDLE;
                    end else begin
                        // Keep the half that still brackets a sign change.
                        if (w_same) begin
                            r_high <= r_mid;
                            r_f_hi <= r_f_mid;
                        end else begin
                            r_low  <= r_mid;
                            r_f_lo <= r_f_mid;
                        end
                        if (r_iter == LAST_ITER) begin
                            r_done                 <= 1'b1;
                            r_result.root          <= w_new_low;
                            r_result.finish_reason <= qrb_pkg::R_LIMIT;
                            r_state                <= S_IDLE;
                        end else begin
                            r_iter      <= r_iter + ITER_W'(1);
                            r_issue_tag <= qrb_pkg::TAG_MID;
                            r_state     <= S_ISSUE;
                        end
                    end
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // A result only follows a decide cycle.
    a_done_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DECIDE))
        else $error("result strobe without a decide cycle");

    // The chain is drained whenever the controller decides.
    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (!w_fres.vld && !w_tok[qrb_pkg::NCELL].vld
                                   && !w_tok[1].vld))
        else $error("evaluation still in flight at decide");

    // Iteration counter never passes the limit.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_iter <= LAST_ITER))
        else $error("iteration counter past limit");

    // A job ends only by delivering its result.
    a_busy_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("job ended without a result");

endmodule

/* test/tb_top.sv */
// Testbench for the quadratic root bisection block: job driver, predictor and result checker.
module tb_top;

    // Slowest job: the block stops at the iteration limit.
    localparam int JOB_LAT = 7 * qrb_pkg::MAX_ITER_DEF + 3;
    localparam int FRAC    = qrb_pkg::FRAC_BITS_DEF;
    localparam int Q_ONE   = 1 << FRAC;
    localparam int XW      = qrb_pkg::XW;
    localparam int TOL_W   = qrb_pkg::TOL_W;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    qrb_pkg::t_job      i_job       = '0;
    logic               o_done;
    qrb_pkg::t_result   o_result;
    logic               i_cfg_we    = 1'b0;
    logic [TOL_W-1:0]   i_cfg_wdata = '0;

    quadratic_root_bisection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_job       (i_job),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Job words waiting to be offered, and results owed by the block in order.
    qrb_pkg::t_job    pending_jobs[$];
    qrb_pkg::t_result owed_roots[$];
    // Tolerance as the block holds it; only changes while the block is idle.
    logic [TOL_W-1:0] tol_now     = qrb_pkg::TOL_RESET;
    bit               steady      = 1'b0;   // suppress sender gaps
    bit               sender_gap;
    int               mismatches  = 0;
    int               jobs_taken  = 0;
    int               settings    = 1;
    int               reason_seen[4] = '{0, 0, 0, 0};

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // f(x) = floor((a*x*x + b*x*2^F + c*2^2F) / 2^2F), exact at 128 bits, then saturated.
    function automatic logic signed [XW-1:0] quad_value(qrb_pkg::t_job j,
                                                        logic signed [XW-1:0] x);
        logic signed [127:0] a, b, c, xx, acc;
        a   = $signed(j.coef_square);
        b   = $signed(j.coef_linear);
        c   = $signed(j.coef_const);
        xx  = $signed(x);
        acc = a * xx * xx + ((b * xx) <<< FRAC) + (c <<< (2 * FRAC));
        acc = acc >>> (2 * FRAC);
        if (acc > $signed(qrb_pkg::F_MAX))
            return qrb_pkg::F_MAX;
        if (acc < $signed(qrb_pkg::F_MIN))
            return qrb_pkg::F_MIN;
        return acc[XW-1:0];
    endfunction

    // Run the whole bisection for one job word and return the result word.
    function automatic qrb_pkg::t_result find_root(qrb_pkg::t_job j, logic [TOL_W-1:0] tol);
        logic signed [XW-1:0] lo, hi, mid, f_lo, f_hi, f_mid;
        logic signed [XW:0]   sum;
        longint               eps;
        qrb_pkg::t_result     r;
        lo  = j.start_low;
        hi  = j.start_high;
        eps = longint'(tol);
        for (int n = 0; n < qrb_pkg::MAX_ITER_DEF; n++) begin
            sum   = (XW+1)'(lo) + (XW+1)'(hi);
            mid   = sum[XW:1];      // floor of the 33-bit sum, always fits
            f_mid = quad_value(j, mid);
            f_hi  = quad_value(j, hi);
            f_lo  = quad_value(j, lo);
            if (mag(longint'(f_lo)) < eps) begin
                r.root = lo;
                r.finish_reason = qrb_pkg::R_LOW_SMALL;
                return r;
            end else if (mag(longint'(f_hi)) < eps) begin
                r.root = hi;
                r.finish_reason = qrb_pkg::R_HIGH_SMALL;
                return r;
            end else if (mag(longint'(lo) - longint'(hi)) < eps) begin
                r.root = lo;
                r.finish_reason = qrb_pkg::R_NARROW;
                return r;
            end else if ((f_mid >= 0) == (f_hi >= 0)) begin
                hi = mid;
            end else begin
                lo = mid;
            end
        end
        r.root = lo;
        r.finish_reason = qrb_pkg::R_LIMIT;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_job(input int lo, input int hi, input int a, input int b, input int c);
        qrb_pkg::t_job j;
        j.start_low   = lo;
        j.start_high  = hi;
        j.coef_square = a;
        j.coef_linear = b;
        j.coef_const  = c;
        pending_jobs.push_back(j);
    endtask

    function automatic int edge_value();
        unique case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return qrb_pkg::F_MIN;
            4:       return qrb_pkg::F_MAX;
            5:       return Q_ONE;
            6:       return -Q_ONE;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly jobs whose interval brackets a root, so the search runs deep, some of
    // them linear; the rest are raw noise and edge values.
    function automatic qrb_pkg::t_job random_job();
        qrb_pkg::t_job j;
        int     r1, r2, a, b, w_lo, w_hi, tmp;
        longint lb, lc;
        int     kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            r1 = near(64 * Q_ONE);
            r2 = near(64 * Q_ONE);
            a  = (kind < 55) ? near(4 * Q_ONE) : 0;
            b  = near(16 * Q_ONE);
            if (a != 0) begin
                lb = -((longint'(a) * (longint'(r1) + longint'(r2))) >>> FRAC);
                lc = (((longint'(a) * r1) >>> FRAC) * r2) >>> FRAC;
            end else begin
                lb = b;
                lc = -((longint'(b) * r1) >>> FRAC);
            end
            w_lo = $urandom_range(0, 1 << ($urandom_range(4, 24)));
            w_hi = $urandom_range(0, 1 << ($urandom_range(4, 24)));
            j.start_low   = r1 - w_lo;
            j.start_high  = r1 + w_hi;
            j.coef_square = a;
            j.coef_linear = lb[XW-1:0];
            j.coef_const  = lc[XW-1:0];
            if ($urandom_range(0, 3) == 0) begin
                // reversed interval
                tmp          = j.start_low;
                j.start_low  = j.start_high;
                j.start_high = tmp;
            end
        end else if (kind < 85) begin
            j = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            j.start_low   = edge_value();
            j.start_high  = edge_value();
            j.coef_square = edge_value();
            j.coef_linear = edge_value();
            j.coef_const  = edge_value();
        end
        return j;
    endfunction

    task automatic add_random(input int n);
        @(negedge i_clk);
        repeat (n) pending_jobs.push_back(random_job());
    endtask

    // Hold until every job is taken and every owed result has come back.
    task automatic drain();
        @(negedge i_clk);
        while (pending_jobs.size() != 0 || owed_roots.size() != 0 || start || busy)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_tol(input logic [TOL_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tol_now      = v;
        settings++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the oldest pending word; on acceptance predict its result
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the word until the block takes it
        end else begin
            if (start) begin
                owed_roots.push_back(find_root(pending_jobs.pop_front(), tol_now));
                jobs_taken++;
            end
            sender_gap = !steady && ($urandom_range(0, 99) < 9);
            if (pending_jobs.size() != 0 && !sender_gap) begin
                start <= 1'b1;
                i_job <= pending_jobs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result word must match the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        qrb_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (owed_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: root %h reason %0d",
                             o_result.root, o_result.finish_reason);
            end else begin
                want = owed_roots.pop_front();
                reason_seen[o_result.finish_reason]++;
                if (o_result.root !== want.root ||
                    o_result.finish_reason !== want.finish_reason) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: root %h/%h reason %0d/%0d (exp/got)",
                                 want.root, o_result.root,
                                 want.finish_reason, o_result.finish_reason);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed jobs at the reset tolerance.
        @(negedge i_clk);
        add_job(0, 0, 0, 0, 0);                                   // f is zero: low end small
        add_job(0, 10 * Q_ONE, Q_ONE, 0, -4 * Q_ONE);              // x^2 - 4, root 2
        add_job(10 * Q_ONE, 0, Q_ONE, 0, -4 * Q_ONE);              // same, reversed interval
        add_job(0, 3 * Q_ONE, 0, Q_ONE, -3 * Q_ONE);               // root sits on the high end
        add_job(5 * Q_ONE, 5 * Q_ONE, 0, 0, 100 * Q_ONE);          // degenerate interval
        add_job(-1000 * Q_ONE, 1000 * Q_ONE, 0, 0, Q_ONE);         // no root: narrows down
        add_job(0, 4 * Q_ONE, -Q_ONE, 0, 2 * Q_ONE);               // -x^2 + 2, root sqrt 2
        add_job(-10 * Q_ONE, 0, Q_ONE, Q_ONE, -6 * Q_ONE);         // x^2 + x - 6, root -3
        // saturation at both ends
        add_job(qrb_pkg::F_MIN, qrb_pkg::F_MAX, qrb_pkg::F_MAX, qrb_pkg::F_MAX, qrb_pkg::F_MAX);
        add_job(qrb_pkg::F_MAX, qrb_pkg::F_MIN, qrb_pkg::F_MIN, qrb_pkg::F_MIN, qrb_pkg::F_MIN);
        add_job(qrb_pkg::F_MAX, qrb_pkg::F_MAX, qrb_pkg::F_MAX, qrb_pkg::F_MAX, qrb_pkg::F_MAX);
        add_job(qrb_pkg::F_MIN, qrb_pkg::F_MIN, qrb_pkg::F_MIN, qrb_pkg::F_MIN, qrb_pkg::F_MIN);
        add_job(-1, -1, -1, -1, -1);
        add_job(qrb_pkg::F_MIN, qrb_pkg::F_MIN + 1, 0, 0, Q_ONE);  // tiny interval at the bottom
        add_job(-1, 1, qrb_pkg::F_MIN, 0, qrb_pkg::F_MAX);
        add_job(qrb_pkg::F_MAX - 1, qrb_pkg::F_MAX, 0, Q_ONE, qrb_pkg::F_MIN);
        add_random(300);
        drain();

        // Zero tolerance: every job runs into the iteration limit.
        write_tol('0);
        @(negedge i_clk);
        add_job(0, 10 * Q_ONE, Q_ONE, 0, -4 * Q_ONE);
        add_job(0, 0, 0, 0, 0);
        add_job(7 * Q_ONE, 7 * Q_ONE, 0, 0, 0);
        add_random(60);
        drain();

        // Widest tolerance.
        write_tol({TOL_W{1'b1}});
        add_random(100);
        drain();

        // Finest nonzero tolerance, sender never pausing.
        write_tol(TOL_W'(1));
        steady = 1'b1;
        add_random(500);
        drain();
        steady = 1'b0;

        write_tol(TOL_W'($urandom_range(2, 1 << 20)));
        add_random(400);
        drain();

        write_tol(TOL_W'(Q_ONE));
        add_random(550);
        drain();

        repeat (JOB_LAT) @(posedge i_clk);
        $display("ran %0d jobs over %0d tolerance settings, reset value and both extremes",
                 jobs_taken, settings);
        $display("finish reasons low/high/narrow/limit: %0d/%0d/%0d/%0d, mismatches %0d",
                 reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3], mismatches);
        if (mismatches == 0 && owed_roots.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #100_000_000;
        $display("timeout with %0d results still owed", owed_roots.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
